>>> design/cmf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cmf_pkg
// Shared types and constants of the credit message fragmenter: transfer
// structs, queue entry layout, controller states and control/status bundles.
// ============================================================================
package cmf_pkg;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_CREDIT  = 1'b1;

    localparam int RESULT_LIMIT = 16;
    localparam int RUN_W        = $clog2(RESULT_LIMIT + 1);

    typedef struct packed {
        logic        action;
        logic [31:0] message_length;
        logic [3:0]  message_opcode;
        logic [31:0] credit_amount;
    } item_t;

    typedef struct packed {
        logic        frame_valid;
        logic        frame_final;
        logic [3:0]  frame_opcode;
        logic [31:0] frame_offset;
        logic [31:0] frame_length;
        logic        enqueue_dropped;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] length;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_EMIT,
        ST_DROP
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd;
        logic load;
        logic emit;
        logic emit_drop;
    } ctl_cmd_t;

    typedef struct packed {
        logic work;
        logic run_zero;
        logic dropped;
        logic pops;
        logic out_free;
    } ctl_sts_t;

endpackage

>>> design/credit_message_fragmenter.sv
`timescale 1ns / 1ps
// ============================================================================
// credit_message_fragmenter
// Credit-based fragmentation of queued message descriptors into frames.
// ============================================================================
// Each input transfer either enqueues a message descriptor or adds byte
// credit; the block then emits frame descriptors for queued messages from
// the head while credit and queued messages last, at most 16 per input. An
// input is taken in the idle state and its action is applied; the next
// cycle checks for work. Each frame takes a queue read, a rest computation
// and an emit step, set by the registered read port of the queue memory;
// the emit waits while the result side stalls. The work check shares the
// cycle of the queue read, so a run that ends on a frame completing its
// message returns to read for a final check. An input with no result passes
// only idle and read; a dropped enqueue with no frame adds a drop step that
// emits its drop report. The input is stalled until the run completes.
module credit_message_fragmenter #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  cmf_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output cmf_pkg::result_t  result
);

    cmf_pkg::ctl_cmd_t cmd;
    cmf_pkg::ctl_sts_t sts;

    cmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cmf_dpath #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cmd         (cmd),
        .sts         (sts),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

endmodule

>>> design/cmf_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// cmf_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cmf_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/cmf_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// cmf_ctrl
// Controller: accepts one item, then walks read, load and emit steps for
// each frame until credit, queue or run limit is exhausted, or a drop step.
// ============================================================================
module cmf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  cmf_pkg::ctl_sts_t  sts,
    output cmf_pkg::ctl_cmd_t  cmd
);

    cmf_pkg::state_t state_reg;
    cmf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cmf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmf_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = cmf_pkg::ST_READ;
                end
            end
            cmf_pkg::ST_READ:
            begin
                priority if (sts.work)
                begin
                    state_next = cmf_pkg::ST_LOAD;
                end
                else if (sts.run_zero && sts.dropped)
                begin
                    state_next = cmf_pkg::ST_DROP;
                end
                else
                begin
                    state_next = cmf_pkg::ST_IDLE;
                end
            end
            cmf_pkg::ST_LOAD:
            begin
                state_next = cmf_pkg::ST_EMIT;
            end
            cmf_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.pops ? cmf_pkg::ST_READ : cmf_pkg::ST_IDLE;
                end
            end
            cmf_pkg::ST_DROP:
            begin
                if (sts.out_free)
                begin
                    state_next = cmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cmf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            cmf_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
            end
            cmf_pkg::ST_READ:
            begin
                cmd.rd = sts.work;
            end
            cmf_pkg::ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            cmf_pkg::ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            cmf_pkg::ST_DROP:
            begin
                cmd.emit_drop = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/cmf_dpath.sv
`timescale 1ns / 1ps
// ============================================================================
// cmf_dpath
// Datapath: message queue with pointers, credit and progress counters,
// frame computation and the result output register.
// ============================================================================
module cmf_dpath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmf_pkg::item_t     item,
    input  cmf_pkg::ctl_cmd_t  cmd,
    output cmf_pkg::ctl_sts_t  sts,
    output logic               result_valid,
    input  logic               result_stall,
    output cmf_pkg::result_t   result
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return ptr + PTR_W'(1);
    endfunction

    logic [PTR_W-1:0]         head_reg, head_next;
    logic [PTR_W-1:0]         tail_reg, tail_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [31:0]              sent_reg, sent_next;
    logic [31:0]              credit_reg, credit_next;
    logic                     dropped_reg, dropped_next;
    logic [cmf_pkg::RUN_W-1:0] run_reg, run_next;
    logic [31:0]              rest_reg, rest_next;
    logic [3:0]               op_reg, op_next;
    logic                     result_valid_reg, result_valid_next;
    cmf_pkg::result_t         result_reg, result_next;

    logic                     wr_en;
    cmf_pkg::entry_t          wr_entry;
    cmf_pkg::entry_t          rd_entry;
    logic [32:0]              credit_sum;
    logic [31:0]              credit_left;
    logic                     pops;
    logic                     last;

    cmf_ram #(
        .WIDTH($bits(cmf_pkg::entry_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(tail_reg),
        .wr_data(wr_entry),
        .rd_en  (cmd.rd),
        .rd_addr(head_reg),
        .rd_data(rd_entry)
    );

    assign wr_entry.opcode = item.message_opcode;
    assign wr_entry.length = item.message_length;

    assign credit_sum  = {1'b0, credit_reg} + {1'b0, item.credit_amount};
    assign credit_left = credit_reg - rest_reg;
    assign pops        = credit_reg >= rest_reg;
    assign last        = !pops || credit_left == 32'd0 || count_reg == CNT_W'(1)
                         || run_reg == cmf_pkg::RUN_W'(cmf_pkg::RESULT_LIMIT - 1);

    assign sts.work     = credit_reg != 32'd0 && count_reg != '0
                          && run_reg < cmf_pkg::RUN_W'(cmf_pkg::RESULT_LIMIT);
    assign sts.run_zero = run_reg == '0;
    assign sts.dropped  = dropped_reg;
    assign sts.pops     = pops;
    assign sts.out_free = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        sent_next         = sent_reg;
        credit_next       = credit_reg;
        dropped_next      = dropped_reg;
        run_next          = run_reg;
        rest_next         = rest_reg;
        op_next           = op_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        wr_en             = 1'b0;

        if (cmd.accept)
        begin
            run_next     = '0;
            dropped_next = 1'b0;
            if (item.action == cmf_pkg::ACT_CREDIT)
            begin
                credit_next = credit_sum[32] ? 32'hFFFF_FFFF : credit_sum[31:0];
            end
            else if (count_reg == CNT_W'(QUEUE_DEPTH))
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                wr_en      = 1'b1;
                tail_next  = advance(tail_reg);
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (cmd.load)
        begin
            rest_next = (rd_entry.length >= sent_reg) ? rd_entry.length - sent_reg : 32'd0;
            op_next   = (sent_reg != 32'd0) ? 4'd0 : rd_entry.opcode;
        end

        if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (cmd.emit)
        begin
            result_valid_next           = 1'b1;
            result_next.frame_valid     = 1'b1;
            result_next.frame_final     = pops;
            result_next.frame_opcode    = op_reg;
            result_next.frame_offset    = sent_reg;
            result_next.frame_length    = pops ? rest_reg : credit_reg;
            result_next.enqueue_dropped = dropped_reg;
            result_next.last_of_run     = last;
            run_next                    = run_reg + cmf_pkg::RUN_W'(1);
            if (pops)
            begin
                credit_next = credit_left;
                head_next   = advance(head_reg);
                count_next  = count_reg - CNT_W'(1);
                sent_next   = 32'd0;
            end
            else
            begin
                sent_next   = sent_reg + credit_reg;
                credit_next = 32'd0;
            end
        end

        if (cmd.emit_drop)
        begin
            result_valid_next           = 1'b1;
            result_next                 = '0;
            result_next.enqueue_dropped = 1'b1;
            result_next.last_of_run     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            sent_reg         <= '0;
            credit_reg       <= '0;
            dropped_reg      <= 1'b0;
            run_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            sent_reg         <= sent_next;
            credit_reg       <= credit_next;
            dropped_reg      <= dropped_next;
            run_reg          <= run_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg   <= rest_next;
        op_reg     <= op_next;
        result_reg <= result_next;
    end

endmodule

>>> design/cmf_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// cmf_checker
// Port-level checks of the credit message fragmenter, bound to the top level.
// ============================================================================
module cmf_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input cmf_pkg::result_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input taken again before run completed");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.frame_valid |->
            result.enqueue_dropped && result.last_of_run && result.frame_length == 32'd0)
        else $error("result without frame is not a lone drop report");

    a_partial_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_valid && !result.frame_final |->
            result.last_of_run && result.frame_length != 32'd0)
        else $error("partial frame does not end its run");

endmodule

bind credit_message_fragmenter cmf_checker u_cmf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
);

>>> tb/frame_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// frame_scoreboard_pkg
// Frame predictor and scoreboard for the credit message fragmenter bench.
// Tracks the message queue, byte credit and sent count of the head message,
// predicts the frame descriptors of every accepted input, and checks each
// accepted result in order against them.
// ============================================================================
package frame_scoreboard_pkg;

    import cmf_pkg::*;

    localparam int          QUEUE_DEPTH     = 16;
    localparam logic [3:0]  OP_CONTINUATION = 4'd0;
    localparam int unsigned PRINT_CAP       = 100;

    class frame_scoreboard;

        entry_t      queue_mem [QUEUE_DEPTH];
        int unsigned queue_head;
        int unsigned queue_tail;
        int unsigned queue_count;
        logic [31:0] head_sent;
        logic [31:0] credit;
        result_t     expected_frames [$];
        int unsigned frames_checked;
        int unsigned mismatches;

        function new();
            queue_head     = 0;
            queue_tail     = 0;
            queue_count    = 0;
            head_sent      = '0;
            credit         = '0;
            frames_checked = 0;
            mismatches     = 0;
        endfunction

        function int unsigned outstanding();
            return expected_frames.size();
        endfunction

        function void note_item(item_t it);
            logic        dropped;
            logic [32:0] sum;
            logic [31:0] rest;
            entry_t      head_entry;
            result_t     frame;
            result_t     run [$];

            dropped = 1'b0;
            if (it.action == ACT_ENQUEUE)
            begin
                if (queue_count >= QUEUE_DEPTH)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    queue_mem[queue_tail].opcode = it.message_opcode;
                    queue_mem[queue_tail].length = it.message_length;
                    queue_tail  = (queue_tail + 1) % QUEUE_DEPTH;
                    queue_count = queue_count + 1;
                end
            end
            else
            begin
                sum    = {1'b0, credit} + {1'b0, it.credit_amount};
                credit = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end

            while (credit != 0 && queue_count != 0 && run.size() < RESULT_LIMIT)
            begin
                head_entry = queue_mem[queue_head];
                rest = (head_entry.length >= head_sent) ? head_entry.length - head_sent : '0;
                frame = '0;
                frame.frame_valid     = 1'b1;
                frame.frame_opcode    = (head_sent != 0) ? OP_CONTINUATION : head_entry.opcode;
                frame.frame_offset    = head_sent;
                frame.enqueue_dropped = dropped;
                if (credit < rest)
                begin
                    frame.frame_length = credit;
                    head_sent          = head_sent + credit;
                    credit             = '0;
                end
                else
                begin
                    frame.frame_final  = 1'b1;
                    frame.frame_length = rest;
                    credit             = credit - rest;
                    queue_head         = (queue_head + 1) % QUEUE_DEPTH;
                    queue_count        = queue_count - 1;
                    head_sent          = '0;
                end
                run.push_back(frame);
            end

            if (run.size() == 0 && dropped)
            begin
                frame = '0;
                frame.enqueue_dropped = 1'b1;
                run.push_back(frame);
            end
            if (run.size() != 0)
            begin
                frame = run.pop_back();
                frame.last_of_run = 1'b1;
                run.push_back(frame);
            end
            foreach (run[i])
                expected_frames.push_back(run[i]);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_CAP)
                $display("MISMATCH: %s", msg);
            mismatches = mismatches + 1;
        endtask

        task compare_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("frame %0d %s: got 0x%0h, want 0x%0h",
                                          frames_checked, field, got, want));
        endtask

        task check_frame(result_t got);
            result_t want;

            if (expected_frames.size() == 0)
            begin
                report_mismatch($sformatf("frame %0d unexpected: 0x%0h", frames_checked, got));
            end
            else
            begin
                want = expected_frames.pop_front();
                compare_field("frame_valid",
                              32'(got.frame_valid), 32'(want.frame_valid));
                compare_field("frame_final",
                              32'(got.frame_final), 32'(want.frame_final));
                compare_field("frame_opcode",
                              32'(got.frame_opcode), 32'(want.frame_opcode));
                compare_field("frame_offset", got.frame_offset, want.frame_offset);
                compare_field("frame_length", got.frame_length, want.frame_length);
                compare_field("enqueue_dropped",
                              32'(got.enqueue_dropped), 32'(want.enqueue_dropped));
                compare_field("last_of_run",
                              32'(got.last_of_run), 32'(want.last_of_run));
            end
            frames_checked = frames_checked + 1;
        endtask

    endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Bench for the credit message fragmenter. Directed transfers cover empty
// grants, zero-length and maximum-length messages, credit saturation, a full
// queue with a dropped enqueue and long fragment runs; random transfers then
// mix enqueues and grants under random idling on both channels.
// ============================================================================
module tb_top;

    import cmf_pkg::*;
    import frame_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned RANDOM_ITEMS = 73;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    frame_scoreboard sb;
    bit              calm = 1'b0;
    int unsigned     stall_left = 0;
    int unsigned     cycle_count = 0;

    credit_message_fragmenter #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic int unsigned idle_len();
        int unsigned r;

        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic item_t make_enqueue(logic [31:0] len, logic [3:0] op);
        item_t it;

        it.action         = ACT_ENQUEUE;
        it.message_length = len;
        it.message_opcode = op;
        it.credit_amount  = $urandom;
        return it;
    endfunction

    function automatic item_t make_grant(logic [31:0] amount);
        item_t it;

        it.action         = ACT_CREDIT;
        it.message_length = $urandom;
        it.message_opcode = 4'($urandom_range(0, 15));
        it.credit_amount  = amount;
        return it;
    endfunction

    function automatic logic [31:0] rand_length();
        int unsigned r;

        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 85)
            return $urandom_range(1, 200);
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_credit();
        int unsigned r;

        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 80)
            return $urandom_range(1, 300);
        if (r < 95)
            return $urandom_range(300, 3000);
        return $urandom;
    endfunction

    // Hold the transfer until accepted, then idle.
    task automatic transfer_item(item_t it);
        int unsigned gap;

        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(it);
        gap = idle_len();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid === 1'b1 && !result_stall)
                sb.check_frame(result);
            if (stall_left != 0)
            begin
                result_stall <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                result_stall <= 1'b0;
                stall_left = idle_len();
            end
        end
    end

    initial
    begin
        sb = new();
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        result_stall <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        transfer_item(make_grant(32'd0));
        transfer_item(make_enqueue(32'd0, 4'd1));
        transfer_item(make_grant(32'd1));
        transfer_item(make_enqueue(32'd5, 4'd2));
        transfer_item(make_grant(32'hFFFF_FFFF));
        transfer_item(make_grant(32'hFFFF_FFFF));
        transfer_item(make_enqueue(32'hFFFF_FFFF, 4'd15));
        for (int i = 0; i < QUEUE_DEPTH; i++)
            transfer_item(make_enqueue($urandom_range(1, 64), i[3:0]));
        transfer_item(make_enqueue(32'd7, 4'd3));
        transfer_item(make_grant(32'd100));
        transfer_item(make_grant(32'hFFFF_FFFF));
        transfer_item(make_enqueue(32'hFFFF_FFFF, 4'd9));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 5)
                calm = ~calm;
            if (i == RANDOM_ITEMS / 2)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
                while (sb.outstanding() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 99) < ((i < RANDOM_ITEMS / 2) ? 65 : 35))
                transfer_item(make_enqueue(rand_length(), 4'($urandom_range(0, 15))));
            else
                transfer_item(make_grant(rand_credit()));
        end
        item_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> credit_message_fragmenter.f
design/cmf_pkg.sv
design/cmf_ram.sv
design/cmf_ctrl.sv
design/cmf_dpath.sv
design/credit_message_fragmenter.sv
design/cmf_checker.sv
tb/frame_scoreboard_pkg.sv
tb/tb_top.sv
